>>> hdl/cprm_pkg.sv
// Shared types and codes for the core pair ring matrix.
package cprm_pkg;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [3:0]  source_core;
        logic [3:0]  destination_core;
        logic [31:0] payload_in;
    } t_in_item;

    typedef struct packed {
        logic        done_res;
        logic [31:0] payload_out;
    } t_out_item;

    typedef enum logic [1:0] {
        OUT_FAIL,
        OUT_PUSH,
        OUT_POP
    } t_out_sel;

    typedef struct packed {
        logic     clr_wr;
        logic     load_item;
        logic     cnt_rd;
        logic     cnt_wr;
        logic     slot_wr;
        logic     slot_rd;
        logic     out_load;
        t_out_sel out_sel;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic in_range;
        logic is_pop;
        logic ring_ok;
        logic out_busy;
    } t_sts;

endpackage

>>> hdl/cprm_ram.sv
// Generic simple dual-port RAM with registered read.
module cprm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // hold read data when no read is issued
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/cprm_ctrl.sv
// Sequencer for counter clearing and push/pop handling.
module cprm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  cprm_pkg::t_sts i_sts,
    output cprm_pkg::t_cmd o_cmd
);

    import cprm_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CNT,
        S_SLOT
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_comb begin
        n_state     = r_state;
        cmd         = '0;
        cmd.out_sel = OUT_FAIL;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    cmd.load_item = 1'b1;
                    cmd.cnt_rd    = 1'b1;
                    n_state       = S_CNT;
                end
            end
            S_CNT: begin
                priority if (!i_sts.in_range || !i_sts.ring_ok) begin
                    if (!i_sts.out_busy) begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = OUT_FAIL;
                        n_state      = S_IDLE;
                    end
                end else if (!i_sts.is_pop) begin
                    if (!i_sts.out_busy) begin
                        cmd.slot_wr  = 1'b1;
                        cmd.cnt_wr   = 1'b1;
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = OUT_PUSH;
                        n_state      = S_IDLE;
                    end
                end else begin
                    // advance read counter now, data arrives next cycle
                    cmd.slot_rd = 1'b1;
                    cmd.cnt_wr  = 1'b1;
                    n_state     = S_SLOT;
                end
            end
            S_SLOT: begin
                if (!i_sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_POP;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = cmd;

endmodule

>>> hdl/cprm_dpath.sv
// Item register, counter and slot memories, and result register.
module cprm_dpath #(
    parameter int NUM_CORES    = 16,
    parameter int RING_DEPTH   = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cprm_pkg::t_cmd       i_cmd,
    output cprm_pkg::t_sts       o_sts,
    input  cprm_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output cprm_pkg::t_out_item  o_out_item
);

    import cprm_pkg::*;

    localparam int RING_COUNT = NUM_CORES * NUM_CORES;
    localparam int SLOT_COUNT = RING_COUNT * RING_DEPTH;
    localparam int RW         = $clog2(RING_COUNT);
    localparam int AW         = $clog2(SLOT_COUNT);
    localparam int CW         = $clog2(2 * RING_DEPTH);
    localparam int SW         = $clog2(RING_DEPTH);
    localparam int FW         = CW + 1;

    t_in_item          r_item;
    logic [RW-1:0]     r_ring;
    logic [RW-1:0]     r_clr_addr;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [RW-1:0]     in_ring;
    logic              in_range;
    logic [2*CW-1:0]   cnt_q;
    logic [2*CW-1:0]   cnt_wdata;
    logic [CW-1:0]     w_cnt;
    logic [CW-1:0]     rd_cnt;
    logic [FW-1:0]     fill;
    logic              full;
    logic              empty;
    logic [CW-1:0]     use_cnt;
    logic [SW-1:0]     slot;
    logic [AW-1:0]     slot_addr;
    logic [PAYLOAD_BITS-1:0] slot_wdata;
    logic [PAYLOAD_BITS-1:0] slot_q;
    logic              cnt_we;
    logic [RW-1:0]     cnt_waddr;

    function automatic logic [CW-1:0] f_inc(input logic [CW-1:0] c);
        logic [CW-1:0] res;
        if (32'(c) == 2 * RING_DEPTH - 1) begin
            res = '0;
        end else begin
            res = c + CW'(1);
        end
        return res;
    endfunction

    assign in_ring = RW'(32'(i_in_item.source_core) * NUM_CORES
                         + 32'(i_in_item.destination_core));

    assign in_range = (32'(r_item.source_core) < NUM_CORES)
                   && (32'(r_item.destination_core) < NUM_CORES);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_item;
            r_ring <= in_ring;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + RW'(1);
        end
    end

    // counter word holds {write count, read count} of one ring
    assign w_cnt  = cnt_q[2*CW-1:CW];
    assign rd_cnt = cnt_q[CW-1:0];
    assign fill  = (w_cnt >= rd_cnt) ? (FW'(w_cnt) - FW'(rd_cnt))
                                     : (FW'(w_cnt) + FW'(2 * RING_DEPTH) - FW'(rd_cnt));
    assign full  = 32'(fill) >= RING_DEPTH;
    assign empty = (w_cnt == rd_cnt);

    assign use_cnt = (r_item.opcode == OP_POP) ? rd_cnt : w_cnt;
    assign slot    = (32'(use_cnt) >= RING_DEPTH) ? SW'(use_cnt - CW'(RING_DEPTH))
                                                  : SW'(use_cnt);
    assign slot_addr  = AW'(32'(r_ring) * RING_DEPTH + 32'(slot));
    assign slot_wdata = PAYLOAD_BITS'(r_item.payload_in);

    always_comb begin
        priority if (i_cmd.clr_wr) begin
            cnt_wdata = '0;
        end else if (r_item.opcode == OP_POP) begin
            cnt_wdata = {w_cnt, f_inc(rd_cnt)};
        end else begin
            cnt_wdata = {f_inc(w_cnt), rd_cnt};
        end
    end

    assign cnt_we    = i_cmd.clr_wr || i_cmd.cnt_wr;
    assign cnt_waddr = i_cmd.clr_wr ? r_clr_addr : r_ring;

    cprm_ram #(
        .WIDTH (2 * CW),
        .DEPTH (RING_COUNT)
    ) u_cnt_ram (
        .i_clk     (i_clk),
        .i_wr_en   (cnt_we),
        .i_wr_addr (cnt_waddr),
        .i_wr_data (cnt_wdata),
        .i_rd_en   (i_cmd.cnt_rd),
        .i_rd_addr (in_ring),
        .o_rd_data (cnt_q)
    );

    cprm_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.slot_wr),
        .i_wr_addr (slot_addr),
        .i_wr_data (slot_wdata),
        .i_rd_en   (i_cmd.slot_rd),
        .i_rd_addr (slot_addr),
        .o_rd_data (slot_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            unique case (i_cmd.out_sel)
                OUT_FAIL: r_out <= '{done_res: 1'b0, payload_out: '0};
                OUT_PUSH: r_out <= '{done_res: 1'b1, payload_out: '0};
                OUT_POP:  r_out <= '{done_res: 1'b1, payload_out: 32'(slot_q)};
                default:  r_out <= '{done_res: 1'b0, payload_out: '0};
            endcase
        end
    end

    assign o_sts.clr_last = (32'(r_clr_addr) == RING_COUNT - 1);
    assign o_sts.in_range = in_range;
    assign o_sts.is_pop   = (r_item.opcode == OP_POP);
    assign o_sts.ring_ok  = (r_item.opcode == OP_POP) ? !empty : !full;
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !i_cmd.out_load)
        else $error("result register loaded while a transfer is pending");

    a_slot_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.slot_wr && i_cmd.slot_rd))
        else $error("slot read and write in the same cycle");

    a_cnt_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_rd |=> !i_cmd.cnt_wr || !i_cmd.cnt_rd)
        else $error("counter read and write overlap");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_wr |-> !i_cmd.load_item && !i_cmd.cnt_wr && !i_cmd.slot_wr)
        else $error("item activity during counter clearing");
`endif

endmodule

>>> hdl/core_pair_ring_matrix.sv
// Top level of the core pair ring matrix.
//
// One FIFO ring for each ordered pair of source and destination cores.
// Input channel (i_in_valid / o_in_ready / i_in_item): one push or pop per
// transfer, naming source and destination core. Output channel
// (o_out_valid / i_out_ready / o_out_item): exactly one result per item,
// in order, with done_res and payload_out (popped word, else zero).
// A push or a failed item gives its result after the counter memory read,
// a successful pop after the counter memory read and then the slot memory
// read. One item is in flight at a time, and a stalled output holds it; the
// next input is taken in the cycle after the result is registered, while
// that result still waits for transfer.
// Reset: the per-ring counters are cleared by a pass over all
// NUM_CORES*NUM_CORES counter words, during which o_in_ready is low.
// Slot memory is not cleared. When the receiver stalls, the finished result
// holds in the output register and a later result waits in its stage.
module core_pair_ring_matrix #(
    parameter int NUM_CORES    = 16,
    parameter int RING_DEPTH   = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  cprm_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output cprm_pkg::t_out_item  o_out_item
);

    import cprm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    cprm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cprm_dpath #(
        .NUM_CORES    (NUM_CORES),
        .RING_DEPTH   (RING_DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
